// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers
// shared concurrent assertion forms, clocked on the rising edge, reset masked
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// types and constants of the sprite frame sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int PATTERN_COUNT_DEF = 256;
    localparam int CUSTOM_DEPTH_DEF  = 64;

    localparam int PAT_W      = 8;
    localparam int MODE_W     = 3;
    localparam int INTERVAL_W = 16;
    localparam int INDEX_W    = 6;
    localparam int LENGTH_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [INTERVAL_W-1:0] TICK_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_SET   = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE      = 3'd0,
        MODE_FWD_LOOP  = 3'd1,
        MODE_REV_LOOP  = 3'd2,
        MODE_FWD_ONCE  = 3'd3,
        MODE_REV_ONCE  = 3'd4,
        MODE_PINGPONG  = 3'd5,
        MODE_CUST_LOOP = 3'd6,
        MODE_CUST_ONCE = 3'd7
    } t_mode;

    typedef struct packed {
        t_op                    op;
        t_mode                  mode;
        logic [INTERVAL_W-1:0]  interval;
        logic [PAT_W-1:0]       pattern;
        logic [INDEX_W-1:0]     entry_index;
    } t_cmd;

    typedef struct packed {
        logic [PAT_W-1:0] current_pattern;
        t_mode            current_mode;
        logic             stepped;
    } t_res;

    typedef struct packed {
        logic [PAT_W-1:0]    top_pattern;
        logic [PAT_W-1:0]    bottom_pattern;
        logic [LENGTH_W-1:0] custom_length;
    } t_cfg;

    // result on its way out; pattern comes from the table read when from_ram is set
    typedef struct packed {
        t_res res;
        logic from_ram;
    } t_stage;

endpackage

// ===== sv/sfs_stream_if.sv =====
// ----------------------------------------------------------------------------
// sfs_stream_if
// valid/ready channel carrying one item of type T
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfs_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sfs_ram.sv =====
// ----------------------------------------------------------------------------
// sfs_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sfs_seq.sv =====
// ----------------------------------------------------------------------------
// sfs_seq
// sequencer state and step logic, issues custom order table accesses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfs_seq #(
    parameter int PATTERN_COUNT = sfs_pkg::PATTERN_COUNT_DEF,
    parameter int CUSTOM_DEPTH  = sfs_pkg::CUSTOM_DEPTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fire,
    input  sfs_pkg::t_cmd                               i_cmd,
    input  sfs_pkg::t_cfg                               i_cfg,
    input  logic [sfs_pkg::PAT_W-1:0]                   i_rd_data,
    output logic                                        o_ram_we,
    output logic [(CUSTOM_DEPTH > 1 ? $clog2(CUSTOM_DEPTH) : 1)-1:0] o_ram_waddr,
    output logic [sfs_pkg::PAT_W-1:0]                   o_ram_wdata,
    output logic                                        o_ram_re,
    output logic [(CUSTOM_DEPTH > 1 ? $clog2(CUSTOM_DEPTH) : 1)-1:0] o_ram_raddr,
    output sfs_pkg::t_stage                             o_res
);
    localparam int PW = $clog2(PATTERN_COUNT);
    localparam int CW = (PW > sfs_pkg::PAT_W) ? PW : sfs_pkg::PAT_W;
    localparam int AW = (CUSTOM_DEPTH > 1) ? $clog2(CUSTOM_DEPTH) : 1;
    localparam int LW = ($clog2(CUSTOM_DEPTH + 1) > sfs_pkg::LENGTH_W) ?
                        $clog2(CUSTOM_DEPTH + 1) : sfs_pkg::LENGTH_W;
    localparam int TAB_N = 2 ** sfs_pkg::PAT_W;
    localparam logic [PW-1:0] PAT_MAX = PW'(PATTERN_COUNT - 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(CUSTOM_DEPTH);

    // reduction of an 8-bit pattern number modulo the pattern count
    logic [PW-1:0] mod_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_mod
        assign mod_tab[g] = PW'(g % PATTERN_COUNT);
    end

    logic [PW-1:0]                  r_pattern, n_pattern;
    logic                           r_pend, n_pend;
    sfs_pkg::t_mode                 r_mode, n_mode;
    logic [sfs_pkg::INTERVAL_W-1:0] r_interval, n_interval;
    logic [sfs_pkg::INTERVAL_W-1:0] r_tick, n_tick;
    logic                           r_back, n_back;
    logic [AW-1:0]                  r_pos, n_pos;

    logic [PW-1:0]                  pat_cur, pat_inc, pat_dec;
    logic [CW-1:0]                  top_c, bot_c, cur_c;
    logic [LW-1:0]                  len_eff, pos_n1;
    logic [AW-1:0]                  pos_c;
    logic                           pos_wrap;
    logic [sfs_pkg::INTERVAL_W-1:0] tick_inc;
    logic                           due, stepped, re, we;

    // a table read from the previous item lands here in the cycle after it is issued
    assign pat_cur = r_pend ? PW'(i_rd_data) : r_pattern;
    assign top_c   = CW'(i_cfg.top_pattern);
    assign bot_c   = CW'(i_cfg.bottom_pattern);
    assign cur_c   = CW'(pat_cur);
    assign pat_inc = (pat_cur == PAT_MAX) ? '0 : pat_cur + PW'(1);
    assign pat_dec = (pat_cur == '0) ? PAT_MAX : pat_cur - PW'(1);

    assign len_eff  = (LW'(i_cfg.custom_length) > DEPTH_L) ? DEPTH_L
                                                           : LW'(i_cfg.custom_length);
    assign pos_c    = (LW'(r_pos) >= len_eff) ? '0 : r_pos;
    assign pos_n1   = LW'(pos_c) + LW'(1);
    assign pos_wrap = (pos_n1 >= len_eff);

    assign tick_inc = (r_tick == sfs_pkg::TICK_MAX) ? r_tick
                                                    : r_tick + sfs_pkg::INTERVAL_W'(1);
    assign due      = (r_interval < tick_inc);

    always_comb begin
        n_pattern  = pat_cur;
        n_pend     = 1'b0;
        n_mode     = r_mode;
        n_interval = r_interval;
        n_tick     = r_tick;
        n_back     = r_back;
        n_pos      = r_pos;
        stepped    = 1'b0;
        re         = 1'b0;
        we         = 1'b0;
        unique case (i_cmd.op)
            sfs_pkg::OP_TICK: begin
                n_tick = tick_inc;
                if (r_mode != sfs_pkg::MODE_IDLE && due) begin
                    n_tick  = '0;
                    stepped = 1'b1;
                    unique case (r_mode)
                        sfs_pkg::MODE_IDLE: begin
                            stepped = 1'b0;
                        end
                        sfs_pkg::MODE_FWD_LOOP: begin
                            n_pattern = (bot_c > cur_c) ? pat_inc
                                                        : mod_tab[i_cfg.top_pattern];
                        end
                        sfs_pkg::MODE_REV_LOOP: begin
                            n_pattern = (top_c < cur_c) ? pat_dec
                                                        : mod_tab[i_cfg.bottom_pattern];
                        end
                        sfs_pkg::MODE_FWD_ONCE: begin
                            if (bot_c > cur_c) begin
                                n_pattern = pat_inc;
                            end else begin
                                n_pattern = mod_tab[i_cfg.bottom_pattern];
                                n_mode    = sfs_pkg::MODE_IDLE;
                            end
                        end
                        sfs_pkg::MODE_REV_ONCE: begin
                            if (top_c < cur_c) begin
                                n_pattern = pat_dec;
                            end else begin
                                n_pattern = mod_tab[i_cfg.top_pattern];
                                n_mode    = sfs_pkg::MODE_IDLE;
                            end
                        end
                        sfs_pkg::MODE_PINGPONG: begin
                            if (r_back) begin
                                if (top_c < cur_c) begin
                                    n_pattern = pat_dec;
                                end else begin
                                    n_pattern = pat_inc;
                                    n_back    = 1'b0;
                                end
                            end else begin
                                if (bot_c > cur_c) begin
                                    n_pattern = pat_inc;
                                end else begin
                                    n_pattern = pat_dec;
                                    n_back    = 1'b1;
                                end
                            end
                        end
                        sfs_pkg::MODE_CUST_LOOP, sfs_pkg::MODE_CUST_ONCE: begin
                            // empty table: counter clears, nothing steps
                            if (len_eff == '0) begin
                                stepped = 1'b0;
                            end else begin
                                re     = 1'b1;
                                n_pend = 1'b1;
                                n_pos  = pos_wrap ? '0 : AW'(pos_n1);
                                if (pos_wrap && r_mode == sfs_pkg::MODE_CUST_ONCE) begin
                                    n_mode = sfs_pkg::MODE_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end
            sfs_pkg::OP_START: begin
                n_mode     = i_cmd.mode;
                n_interval = i_cmd.interval;
                n_back     = 1'b0;
            end
            sfs_pkg::OP_SET: begin
                n_pattern = mod_tab[i_cmd.pattern];
            end
            sfs_pkg::OP_WRITE: begin
                we = (LW'(i_cmd.entry_index) < DEPTH_L);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_pend     <= 1'b0;
            r_mode     <= sfs_pkg::MODE_FWD_LOOP;
            r_interval <= sfs_pkg::INTERVAL_W'(1);
            r_tick     <= '0;
            r_back     <= 1'b0;
            r_pos      <= '0;
        end else if (i_fire) begin
            r_pattern  <= n_pattern;
            r_pend     <= n_pend;
            r_mode     <= n_mode;
            r_interval <= n_interval;
            r_tick     <= n_tick;
            r_back     <= n_back;
            r_pos      <= n_pos;
        end else if (r_pend) begin
            r_pattern <= PW'(i_rd_data);
            r_pend    <= 1'b0;
        end
    end

    // table holds patterns already reduced
    assign o_ram_we    = i_fire && we;
    assign o_ram_waddr = AW'(i_cmd.entry_index);
    assign o_ram_wdata = sfs_pkg::PAT_W'(mod_tab[i_cmd.pattern]);
    assign o_ram_re    = i_fire && re;
    assign o_ram_raddr = pos_c;

    assign o_res.res.current_pattern = sfs_pkg::PAT_W'(n_pattern);
    assign o_res.res.current_mode    = n_mode;
    assign o_res.res.stepped         = stepped;
    assign o_res.from_ram            = n_pend;

    `SFS_ASSERT_IMP(a_pend_after_fire, i_clk, i_rst_n, r_pend, $past(i_fire), "pattern pending without a preceding item")
    `SFS_ASSERT_IMP(a_idle_no_step, i_clk, i_rst_n, i_fire && (r_mode == sfs_pkg::MODE_IDLE), !o_res.res.stepped, "idle mode stepped")
endmodule

// ===== sv/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// per-frame sprite pattern sequencer with custom order table
// ----------------------------------------------------------------------------
// result path: an accepted item is registered into the table stage with its table read, then into the output register
// throughput: one item per cycle while the output is not stalled; a custom step reads the order table in its own cycle
//   and the next item picks the read data up through a forwarding path
// reset: synchronous, active low; mode forward loop, interval 1, pattern, counter,
//   direction and table position zero; table contents undefined until written
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprite_frame_sequencer #(
    parameter int PATTERN_COUNT = sfs_pkg::PATTERN_COUNT_DEF,
    parameter int CUSTOM_DEPTH  = sfs_pkg::CUSTOM_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sfs_stream_if.sink                       i_cmd,
    sfs_stream_if.source                     o_res
);
    localparam int AW = (CUSTOM_DEPTH > 1) ? $clog2(CUSTOM_DEPTH) : 1;

    sfs_pkg::t_cfg   r_cfg;
    sfs_pkg::t_stage r_s1;
    logic            r_s1_valid;
    sfs_pkg::t_res   r_out;
    logic            r_o_valid;

    sfs_pkg::t_stage             seq_res;
    sfs_pkg::t_res               s1_res;
    logic                        out_free, fire;
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [sfs_pkg::PAT_W-1:0]   ram_wdata, ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfs_pkg::CFG_TOP:    r_cfg.top_pattern    <= i_cfg_data;
                sfs_pkg::CFG_BOTTOM: r_cfg.bottom_pattern <= i_cfg_data;
                sfs_pkg::CFG_LENGTH: r_cfg.custom_length  <= sfs_pkg::LENGTH_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign out_free    = !r_o_valid || o_res.ready;
    assign i_cmd.ready = !r_s1_valid || out_free;
    assign fire        = i_cmd.valid && i_cmd.ready;

    sfs_seq #(
        .PATTERN_COUNT (PATTERN_COUNT),
        .CUSTOM_DEPTH  (CUSTOM_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_cmd       (i_cmd.data),
        .i_cfg       (r_cfg),
        .i_rd_data   (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_res       (seq_res)
    );

    sfs_ram #(
        .WIDTH (sfs_pkg::PAT_W),
        .DEPTH (CUSTOM_DEPTH)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read data stays put while the stage waits: no new item, no new read
    always_comb begin
        s1_res = r_s1.res;
        if (r_s1.from_ram) begin
            s1_res.current_pattern = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1 <= seq_res;
        end
        if (out_free && r_s1_valid) begin
            r_out <= s1_res;
        end
    end

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_out;

    `SFS_ASSERT_NXT(a_s1_loaded, i_clk, i_rst_n, fire, r_s1_valid, "accepted item did not reach the table stage")
    `SFS_ASSERT_IMP(a_rd_hold, i_clk, i_rst_n, r_s1_valid && r_s1.from_ram && !out_free, !ram_re, "table read data overwritten while a result waits on it")
endmodule
